>>> rtl/thruster_actuator_model_macros.svh
// assertion macros used by thruster_actuator_model.sv
// every macro samples on clk and is off while rst is high
`ifndef THRUSTER_ACTUATOR_MODEL_MACROS_SVH
`define THRUSTER_ACTUATOR_MODEL_MACROS_SVH

// same-cycle implication
`define TAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tac_pkg.sv
`default_nettype none

package tac_pkg;

  // field widths
  localparam int FORCE_W = 32;
  localparam int CFG_W   = 31;
  localparam int GAIN_W  = 24;
  localparam int ALPHA_W = 17;
  localparam int IDLE_W  = 16;
  localparam int FRAC_W  = 16;
  localparam int INDEX_W = 3;

  // q16 helpers
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
  localparam logic [FRAC_W-1:0]  ROUND_HALF = 16'h8000;

  // register reset values
  localparam logic [CFG_W-1:0]   DEADBAND_RST = '0;
  localparam logic [GAIN_W-1:0]  GAIN_RST     = 24'h010000;
  localparam logic [CFG_W-1:0]   LIMIT_RST    = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_RST    = ALPHA_ONE;
  localparam logic [CFG_W-1:0]   SLEW_RST     = '0;

  // delay line length default and watchdog timeout (zero disables)
  localparam int                DELAY_TICKS_DEFAULT = 4;
  localparam logic [IDLE_W-1:0] TIMEOUT_TICKS       = 16'd100;

  typedef enum logic [INDEX_W-1:0] {
    REG_DEADBAND      = 3'd0,
    REG_FORWARD_GAIN  = 3'd1,
    REG_REVERSE_GAIN  = 3'd2,
    REG_FORWARD_LIMIT = 3'd3,
    REG_REVERSE_LIMIT = 3'd4,
    REG_RISE_ALPHA    = 3'd5,
    REG_FALL_ALPHA    = 3'd6,
    REG_SLEW_STEP     = 3'd7
  } cfg_reg_t;

  // per-cell control of the delay line
  typedef struct packed {
    logic shift;  // a tick moves every entry one cell toward the head
    logic flush;  // watchdog drops all pending commands
    logic load;   // a shaped command enters this cell
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/tac_cell.sv
`default_nettype none

// one slot of the command delay line
module tac_cell (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire tac_pkg::cell_ctrl_t            ctrl,
  input  wire logic signed [tac_pkg::FORCE_W-1:0] load_force,
  input  wire logic signed [tac_pkg::FORCE_W-1:0] next_force,
  input  wire                                 next_valid,
  output logic signed [tac_pkg::FORCE_W-1:0]      force_q,
  output logic                                valid
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.flush) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end
  end

  // payload, only read while valid
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      force_q <= next_force;
    end else if (ctrl.load) begin
      force_q <= load_force;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tac_shape.sv
`default_nettype none

// command shaping: deadband, gain with rounding, limit clamp
module tac_shape (
  input  wire logic signed [tac_pkg::FORCE_W-1:0] force_command,
  input  wire logic [tac_pkg::CFG_W-1:0]          deadband,
  input  wire logic [tac_pkg::GAIN_W-1:0]         forward_gain,
  input  wire logic [tac_pkg::GAIN_W-1:0]         reverse_gain,
  input  wire logic [tac_pkg::CFG_W-1:0]          forward_limit,
  input  wire logic [tac_pkg::CFG_W-1:0]          reverse_limit,
  output logic signed [tac_pkg::FORCE_W-1:0]      shaped
);

  localparam int PROD_W = tac_pkg::FORCE_W + tac_pkg::GAIN_W;

  logic                          neg;
  logic [tac_pkg::FORCE_W-1:0]   mag;
  logic [tac_pkg::GAIN_W-1:0]    gain;
  logic [tac_pkg::CFG_W-1:0]     limit;
  logic [PROD_W:0]               prod;
  logic [PROD_W-tac_pkg::FRAC_W:0] scaled;
  logic [tac_pkg::CFG_W-1:0]     clamped;
  logic [tac_pkg::FORCE_W-1:0]   pos_out;

  always_comb begin
    neg   = force_command[tac_pkg::FORCE_W-1];
    mag   = neg ? (~force_command + 1'b1) : force_command;
    gain  = neg ? reverse_gain : forward_gain;
    limit = neg ? reverse_limit : forward_limit;
    // round to nearest on the magnitude, ties away from zero
    prod   = {1'b0, {{tac_pkg::GAIN_W{1'b0}}, mag} * {{tac_pkg::FORCE_W{1'b0}}, gain}}
           + {{(PROD_W + 1 - tac_pkg::FRAC_W){1'b0}}, tac_pkg::ROUND_HALF};
    scaled = prod[PROD_W:tac_pkg::FRAC_W];
    if (scaled > {{(PROD_W + 1 - tac_pkg::FRAC_W - tac_pkg::CFG_W){1'b0}}, limit}) begin
      clamped = limit;
    end else begin
      clamped = scaled[tac_pkg::CFG_W-1:0];
    end
    if (mag < {1'b0, deadband}) begin
      pos_out = '0;
    end else begin
      pos_out = {1'b0, clamped};
    end
    shaped = neg ? (~pos_out + 1'b1) : pos_out;
  end

endmodule

`default_nettype wire

>>> rtl/tac_lag.sv
`default_nettype none

// one step of the asymmetric first-order lag with slew limit
module tac_lag (
  input  wire logic signed [tac_pkg::FORCE_W-1:0] force_now,
  input  wire logic signed [tac_pkg::FORCE_W-1:0] force_goal,
  input  wire logic [tac_pkg::ALPHA_W-1:0]        rise_alpha,
  input  wire logic [tac_pkg::ALPHA_W-1:0]        fall_alpha,
  input  wire logic [tac_pkg::CFG_W-1:0]          slew_step,
  output logic signed [tac_pkg::FORCE_W-1:0]      force_next
);

  localparam int PROD_W = tac_pkg::FORCE_W + tac_pkg::ALPHA_W;

  logic signed [tac_pkg::FORCE_W:0] diff;
  logic                             neg;
  logic [tac_pkg::FORCE_W:0]        mag_w;
  logic [tac_pkg::FORCE_W-1:0]      mag;
  logic [tac_pkg::FORCE_W-1:0]      ag;
  logic [tac_pkg::FORCE_W-1:0]      an;
  logic                             g_pos;
  logic                             n_pos;
  logic                             opposite;
  logic [tac_pkg::ALPHA_W-1:0]      alpha_sel;
  logic [tac_pkg::ALPHA_W-1:0]      alpha;
  logic [PROD_W:0]                  prod;
  logic [tac_pkg::FORCE_W-1:0]      step;
  logic [tac_pkg::FORCE_W:0]        sum;

  always_comb begin
    diff  = {force_goal[tac_pkg::FORCE_W-1], force_goal}
          - {force_now[tac_pkg::FORCE_W-1], force_now};
    neg   = diff[tac_pkg::FORCE_W];
    mag_w = neg ? (~diff + 1'b1) : diff;
    mag   = mag_w[tac_pkg::FORCE_W-1:0];
    ag    = force_goal[tac_pkg::FORCE_W-1] ? (~force_goal + 1'b1) : force_goal;
    an    = force_now[tac_pkg::FORCE_W-1] ? (~force_now + 1'b1) : force_now;
    g_pos = !force_goal[tac_pkg::FORCE_W-1] && (force_goal != '0);
    n_pos = !force_now[tac_pkg::FORCE_W-1] && (force_now != '0);
    opposite = (g_pos && force_now[tac_pkg::FORCE_W-1])
            || (force_goal[tac_pkg::FORCE_W-1] && n_pos);
    // rise only while the magnitude grows on the same side
    alpha_sel = (!opposite && (ag > an)) ? rise_alpha : fall_alpha;
    alpha     = (alpha_sel > tac_pkg::ALPHA_ONE) ? tac_pkg::ALPHA_ONE : alpha_sel;
    prod = {1'b0, {{tac_pkg::ALPHA_W{1'b0}}, mag} * {{tac_pkg::FORCE_W{1'b0}}, alpha}}
         + {{(PROD_W + 1 - tac_pkg::FRAC_W){1'b0}}, tac_pkg::ROUND_HALF};
    // rounded step never exceeds the distance, so 32 bits hold it
    step = prod[tac_pkg::FRAC_W +: tac_pkg::FORCE_W];
    if ((slew_step != '0) && (step > {1'b0, slew_step})) begin
      step = {1'b0, slew_step};
    end
    sum = {force_now[tac_pkg::FORCE_W-1], force_now}
        + (neg ? (~{1'b0, step} + 1'b1) : {1'b0, step});
    force_next = sum[tac_pkg::FORCE_W-1:0];
  end

endmodule

`default_nettype wire

>>> rtl/thruster_actuator_model.sv
`default_nettype none

// Thruster channel model. Each transfer on the input side is either a force command
// (action 0) or one time tick (action 1), and each gives exactly one result transfer
// carrying the applied force, the force being approached and the watchdog flag, all
// as they stand after that item. A command is shaped (deadband, forward or reverse gain
// with round-to-nearest, limit clamp) and written into the tail of a row of
// DELAY_TICKS+1 delay cells; each tick shifts the row one cell toward the head, so a
// command becomes the target on the DELAY_TICKS+1-th tick after it, the tick that
// finds it in the head cell, and a second command before the next tick replaces the
// first. On a tick the watchdog runs first: when tac_pkg::TIMEOUT_TICKS is non-zero
// and the channel is stopped or has seen that many ticks without a command, all cells
// are flushed, the target drops to zero and the channel stays stopped until the next
// command. The force then moves toward the target by the rise or fall alpha with
// rounding, capped at slew_step. Rate: one item per clock cycle while in_stall is low; the lag
// update (difference, one 32x17 multiply, round, clamp, add) is combinational and closes
// on the force register, which sets that rate. Each result is registered in the output
// register, or in the skid register while the output is held; this two-entry output
// stage lets the block take one more item while a result waits, and in_stall
// rises only when both are full. No clearing pass after reset. Registers are written
// through cfg_write/cfg_index/cfg_data and should only change while the block is idle.
module thruster_actuator_model #(
  parameter int DELAY_TICKS = tac_pkg::DELAY_TICKS_DEFAULT
) (
  input  wire                                      clk,
  input  wire                                      rst,
  // configuration write port
  input  wire                                      cfg_write,
  input  wire logic [tac_pkg::INDEX_W-1:0]         cfg_index,
  input  wire logic [tac_pkg::CFG_W-1:0]           cfg_data,
  // input channel
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wire                                      action,
  input  wire logic signed [tac_pkg::FORCE_W-1:0]  force_command,
  // output channel
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output logic signed [tac_pkg::FORCE_W-1:0]       applied_force,
  output logic signed [tac_pkg::FORCE_W-1:0]       target_force,
  output logic                                     watchdog_stopped
);

`include "thruster_actuator_model_macros.svh"

  localparam int SLOTS = DELAY_TICKS + 1;
  localparam logic WD_ENABLED = (tac_pkg::TIMEOUT_TICKS != '0);

  // configuration registers
  logic [tac_pkg::CFG_W-1:0]   deadband;
  logic [tac_pkg::GAIN_W-1:0]  forward_gain;
  logic [tac_pkg::GAIN_W-1:0]  reverse_gain;
  logic [tac_pkg::CFG_W-1:0]   forward_limit;
  logic [tac_pkg::CFG_W-1:0]   reverse_limit;
  logic [tac_pkg::ALPHA_W-1:0] rise_alpha;
  logic [tac_pkg::ALPHA_W-1:0] fall_alpha;
  logic [tac_pkg::CFG_W-1:0]   slew_step;

  // channel state
  logic signed [tac_pkg::FORCE_W-1:0] force_now;
  logic signed [tac_pkg::FORCE_W-1:0] force_goal;
  logic [tac_pkg::IDLE_W-1:0]         idle_ticks;
  logic                               stopped_flag;

  // delay line, each cell drives its own slot
  wire logic signed [tac_pkg::FORCE_W-1:0] cell_force [SLOTS];
  wire [SLOTS-1:0]                         cell_valid;
  wire tac_pkg::cell_ctrl_t                cell_ctrl [SLOTS];

  // skid register behind the output register
  logic                               sk_valid;
  logic signed [tac_pkg::FORCE_W-1:0] sk_applied;
  logic signed [tac_pkg::FORCE_W-1:0] sk_target;
  logic                               sk_stopped;

  logic                               in_fire;
  logic                               cmd_fire;
  logic                               tick_fire;
  logic                               out_free;
  logic                               wd_fire;
  logic signed [tac_pkg::FORCE_W-1:0] goal_next;
  logic signed [tac_pkg::FORCE_W-1:0] force_lag;
  logic signed [tac_pkg::FORCE_W-1:0] shaped;
  logic signed [tac_pkg::FORCE_W-1:0] res_applied;
  logic signed [tac_pkg::FORCE_W-1:0] res_target;
  logic                               res_stopped;

  assign in_stall  = sk_valid;
  assign in_fire   = in_valid && !in_stall;
  assign cmd_fire  = in_fire && !action;
  assign tick_fire = in_fire && action;
  assign out_free  = !out_valid || !out_stall;

  // watchdog trips at the start of a tick
  assign wd_fire = WD_ENABLED
                && (stopped_flag || (idle_ticks >= tac_pkg::TIMEOUT_TICKS));

  // a flush empties the head cell too, leaving a zero target
  always_comb begin
    if (wd_fire) begin
      goal_next = '0;
    end else if (cell_valid[0]) begin
      goal_next = cell_force[0];
    end else begin
      goal_next = force_goal;
    end
  end

  tac_shape u_shape (
    .force_command (force_command),
    .deadband      (deadband),
    .forward_gain  (forward_gain),
    .reverse_gain  (reverse_gain),
    .forward_limit (forward_limit),
    .reverse_limit (reverse_limit),
    .shaped        (shaped)
  );

  tac_lag u_lag (
    .force_now  (force_now),
    .force_goal (goal_next),
    .rise_alpha (rise_alpha),
    .fall_alpha (fall_alpha),
    .slew_step  (slew_step),
    .force_next (force_lag)
  );

  // row of delay cells, each fed by its tail-side neighbor
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    logic signed [tac_pkg::FORCE_W-1:0] nb_force;
    logic                               nb_valid;

    if (k == SLOTS - 1) begin : g_tail
      assign nb_force = '0;
      assign nb_valid = 1'b0;
    end else begin : g_body
      assign nb_force = cell_force[k+1];
      assign nb_valid = cell_valid[k+1];
    end

    assign cell_ctrl[k] = '{shift: tick_fire,
                            flush: tick_fire && wd_fire,
                            load:  cmd_fire && (k == SLOTS - 1)};

    tac_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl[k]),
      .load_force (shaped),
      .next_force (nb_force),
      .next_valid (nb_valid),
      .force_q    (cell_force[k]),
      .valid      (cell_valid[k])
    );
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband      <= tac_pkg::DEADBAND_RST;
      forward_gain  <= tac_pkg::GAIN_RST;
      reverse_gain  <= tac_pkg::GAIN_RST;
      forward_limit <= tac_pkg::LIMIT_RST;
      reverse_limit <= tac_pkg::LIMIT_RST;
      rise_alpha    <= tac_pkg::ALPHA_RST;
      fall_alpha    <= tac_pkg::ALPHA_RST;
      slew_step     <= tac_pkg::SLEW_RST;
    end else if (cfg_write) begin
      unique case (tac_pkg::cfg_reg_t'(cfg_index))
        tac_pkg::REG_DEADBAND:      deadband      <= cfg_data;
        tac_pkg::REG_FORWARD_GAIN:  forward_gain  <= cfg_data[tac_pkg::GAIN_W-1:0];
        tac_pkg::REG_REVERSE_GAIN:  reverse_gain  <= cfg_data[tac_pkg::GAIN_W-1:0];
        tac_pkg::REG_FORWARD_LIMIT: forward_limit <= cfg_data;
        tac_pkg::REG_REVERSE_LIMIT: reverse_limit <= cfg_data;
        tac_pkg::REG_RISE_ALPHA:    rise_alpha    <= cfg_data[tac_pkg::ALPHA_W-1:0];
        tac_pkg::REG_FALL_ALPHA:    fall_alpha    <= cfg_data[tac_pkg::ALPHA_W-1:0];
        tac_pkg::REG_SLEW_STEP:     slew_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  // channel state: a tick runs the lag, a command rearms the watchdog
  always_ff @(posedge clk) begin
    if (rst) begin
      force_now    <= '0;
      force_goal   <= '0;
      idle_ticks   <= '0;
      stopped_flag <= 1'b1;
    end else if (tick_fire) begin
      force_now    <= force_lag;
      force_goal   <= goal_next;
      stopped_flag <= stopped_flag || wd_fire;
      if (idle_ticks != '1) begin
        idle_ticks <= idle_ticks + 1'b1;
      end
    end else if (cmd_fire) begin
      idle_ticks   <= '0;
      stopped_flag <= 1'b0;
    end
  end

  // result of the item being transferred in
  always_comb begin
    if (action) begin
      res_applied = force_lag;
      res_target  = goal_next;
      res_stopped = WD_ENABLED && (stopped_flag || wd_fire);
    end else begin
      res_applied = force_now;
      res_target  = force_goal;
      res_stopped = 1'b0;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (out_free) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (sk_valid) begin
        applied_force    <= sk_applied;
        target_force     <= sk_target;
        watchdog_stopped <= sk_stopped;
      end else if (in_fire) begin
        applied_force    <= res_applied;
        target_force     <= res_target;
        watchdog_stopped <= res_stopped;
      end
    end else if (in_fire) begin
      sk_applied <= res_applied;
      sk_target  <= res_target;
      sk_stopped <= res_stopped;
    end
  end

  // skid only fills behind a held output
  `TAC_ASSERT_NOW(a_skid_behind_out, sk_valid, out_valid, "skid full with empty output")
  // a command lands in the tail cell and rearms the watchdog
  `TAC_ASSERT_NEXT(a_cmd_tail, cmd_fire,
    cell_valid[SLOTS-1] && !stopped_flag && (idle_ticks == '0), "command not registered")
  // a watchdog flush empties the whole row and zeroes the target
  `TAC_ASSERT_NEXT(a_flush_clears, tick_fire && wd_fire,
    (cell_valid == '0) && (force_goal == '0) && stopped_flag, "watchdog flush incomplete")
  // a matured command becomes the target
  `TAC_ASSERT_NEXT(a_head_to_goal, tick_fire && !wd_fire && cell_valid[0],
    force_goal == $past(cell_force[0]), "head cell not taken as target")

endmodule

`default_nettype wire

>>> dv/thruster_force_checker.sv
package thruster_tb_pkg;

  // what one input transfer carries
  typedef enum logic {
    ACT_COMMAND = 1'b0,
    ACT_TICK    = 1'b1
  } thrust_action_t;

endpackage

module thruster_force_checker #(
  parameter int DELAY_TICKS = tac_pkg::DELAY_TICKS_DEFAULT
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     cfg_write,
  input  tac_pkg::cfg_reg_t                       cfg_index,
  input  wire logic [tac_pkg::CFG_W-1:0]          cfg_data,
  input  wire                                     in_valid,
  input  wire                                     in_stall,
  input  wire                                     action,
  input  wire logic signed [tac_pkg::FORCE_W-1:0] force_command,
  input  wire                                     out_valid,
  input  wire                                     out_stall,
  input  wire logic signed [tac_pkg::FORCE_W-1:0] applied_force,
  input  wire logic signed [tac_pkg::FORCE_W-1:0] target_force,
  input  wire                                     watchdog_stopped,
  output int                                      failures,
  output int                                      outstanding
);
  import tac_pkg::*;
  import thruster_tb_pkg::*;

  localparam int SLOTS = DELAY_TICKS + 1;
  // expected results in flight; the block holds at most two
  localparam int RING_DEPTH = 8;

  typedef struct {
    logic signed [FORCE_W-1:0] applied;
    logic signed [FORCE_W-1:0] target;
    logic                      stopped;
  } thrust_result_t;

  // register copies
  logic [CFG_W-1:0]   deadband, fwd_limit, rev_limit, slew_step;
  logic [GAIN_W-1:0]  fwd_gain, rev_gain;
  logic [ALPHA_W-1:0] rise_alpha, fall_alpha;

  // channel state
  longint           force_now, force_goal;
  longint           queued_force [SLOTS];
  bit               queued_valid [SLOTS];
  logic [IDLE_W-1:0] idle_count;
  bit               halted;

  // ring of expected results, oldest at ring_rd
  thrust_result_t expected_ring [RING_DEPTH];
  int             ring_rd = 0;
  int             ring_wr = 0;
  int             ring_count = 0;
  int             mismatch_count = 0;
  int             result_count = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("mismatch at %0t, result %0d: %s got %0d expected %0d",
             $time, result_count, what, got, want);
  endtask

  function automatic void reset_channel();
    deadband   = DEADBAND_RST;
    fwd_gain   = GAIN_RST;
    rev_gain   = GAIN_RST;
    fwd_limit  = LIMIT_RST;
    rev_limit  = LIMIT_RST;
    rise_alpha = ALPHA_RST;
    fall_alpha = ALPHA_RST;
    slew_step  = SLEW_RST;
    force_now  = 0;
    force_goal = 0;
    for (int k = 0; k < SLOTS; k++) begin
      queued_force[k] = 0;
      queued_valid[k] = 1'b0;
    end
    idle_count = '0;
    halted     = 1'b1;
    ring_rd    = 0;
    ring_wr    = 0;
    ring_count = 0;
  endfunction

  function automatic void apply_register(cfg_reg_t idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_DEADBAND:      deadband   = val;
      REG_FORWARD_GAIN:  fwd_gain   = val[GAIN_W-1:0];
      REG_REVERSE_GAIN:  rev_gain   = val[GAIN_W-1:0];
      REG_FORWARD_LIMIT: fwd_limit  = val;
      REG_REVERSE_LIMIT: rev_limit  = val;
      REG_RISE_ALPHA:    rise_alpha = val[ALPHA_W-1:0];
      REG_FALL_ALPHA:    fall_alpha = val[ALPHA_W-1:0];
      REG_SLEW_STEP:     slew_step  = val;
    endcase
  endfunction

  // magnitude times a q16 factor, round half up
  function automatic longint unsigned q16_scale(longint unsigned mag, longint unsigned factor);
    return (mag * factor + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
  endfunction

  function automatic longint shape_thrust(logic signed [FORCE_W-1:0] cmd);
    longint          c;
    longint unsigned mag;
    bit              neg;
    c   = cmd;
    neg = c < 0;
    mag = neg ? -c : c;
    if (mag < deadband)
      return 0;
    mag = q16_scale(mag, neg ? rev_gain : fwd_gain);
    if (neg) begin
      if (mag > rev_limit)
        mag = rev_limit;
      return -longint'(mag);
    end
    if (mag > fwd_limit)
      mag = fwd_limit;
    return longint'(mag);
  endfunction

  function automatic void lag_advance();
    longint          diff;
    longint unsigned goal_mag, now_mag, mag, alpha;
    bit              opposite, neg;
    diff     = force_goal - force_now;
    opposite = (force_goal > 0 && force_now < 0) || (force_goal < 0 && force_now > 0);
    goal_mag = (force_goal < 0) ? -force_goal : force_goal;
    now_mag  = (force_now < 0) ? -force_now : force_now;
    alpha    = (!opposite && goal_mag > now_mag) ? rise_alpha : fall_alpha;
    if (alpha > ALPHA_ONE)
      alpha = ALPHA_ONE;
    neg = diff < 0;
    mag = neg ? -diff : diff;
    mag = q16_scale(mag, alpha);
    if (slew_step != 0 && mag > slew_step)
      mag = slew_step;
    force_now = neg ? force_now - longint'(mag) : force_now + longint'(mag);
  endfunction

  function automatic thrust_result_t advance_channel(logic act, logic signed [FORCE_W-1:0] cmd);
    thrust_result_t r;
    if (act == ACT_COMMAND) begin
      queued_force[SLOTS-1] = shape_thrust(cmd);
      queued_valid[SLOTS-1] = 1'b1;
      idle_count = '0;
      halted     = 1'b0;
    end else begin
      // watchdog comes before the matured command
      if (TIMEOUT_TICKS != 0 && (halted || idle_count >= TIMEOUT_TICKS)) begin
        for (int k = 0; k < SLOTS; k++) begin
          queued_force[k] = 0;
          queued_valid[k] = 1'b0;
        end
        force_goal = 0;
        halted     = 1'b1;
      end
      if (queued_valid[0])
        force_goal = queued_force[0];
      for (int k = 0; k + 1 < SLOTS; k++) begin
        queued_force[k] = queued_force[k+1];
        queued_valid[k] = queued_valid[k+1];
      end
      queued_force[SLOTS-1] = 0;
      queued_valid[SLOTS-1] = 1'b0;
      lag_advance();
      if (idle_count != '1)
        idle_count++;
    end
    r.applied = force_now[FORCE_W-1:0];
    r.target  = force_goal[FORCE_W-1:0];
    r.stopped = (TIMEOUT_TICKS != 0) && halted;
    return r;
  endfunction

  always @(posedge clk) begin : track
    thrust_result_t want;
    thrust_result_t got_in;
    if (rst) begin
      reset_channel();
    end else begin
      if (cfg_write)
        apply_register(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        result_count++;
        if (ring_count == 0) begin
          report_mismatch("result with no transfer waiting, applied_force", applied_force, 0);
        end else begin
          want       = expected_ring[ring_rd];
          ring_rd    = (ring_rd + 1) % RING_DEPTH;
          ring_count = ring_count - 1;
          if (applied_force !== want.applied)
            report_mismatch("applied_force", applied_force, want.applied);
          if (target_force !== want.target)
            report_mismatch("target_force", target_force, want.target);
          if (watchdog_stopped !== want.stopped)
            report_mismatch("watchdog_stopped", watchdog_stopped, want.stopped);
        end
      end
      if (in_valid && !in_stall) begin
        got_in = advance_channel(action, force_command);
        if (ring_count == RING_DEPTH) begin
          report_mismatch("transfers in flight beyond the output stage, count",
                          ring_count, 2);
        end else begin
          expected_ring[ring_wr] = got_in;
          ring_wr    = (ring_wr + 1) % RING_DEPTH;
          ring_count = ring_count + 1;
        end
      end
    end
    outstanding <= ring_count;
    failures    <= mismatch_count;
  end

endmodule

>>> dv/thruster_actuator_model_tb.sv
module thruster_actuator_model_tb;
  import tac_pkg::*;
  import thruster_tb_pkg::*;

  localparam int DELAY_TICKS = DELAY_TICKS_DEFAULT;
  // rough number of input transfers in the random part
  localparam int ITEM_BUDGET = 1000;
  localparam int PHASES      = 9;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  cfg_reg_t                  cfg_index = REG_DEADBAND;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  wire                       in_stall;
  thrust_action_t            action = ACT_COMMAND;
  logic signed [FORCE_W-1:0] force_command = '0;
  wire                       out_valid;
  logic                      out_stall = 1'b0;
  wire signed [FORCE_W-1:0]  applied_force;
  wire signed [FORCE_W-1:0]  target_force;
  wire                       watchdog_stopped;

  int failures;
  int outstanding;

  // deadband as last written, so commands can be aimed at its edge
  logic [CFG_W-1:0] cur_deadband = DEADBAND_RST;
  // transfers left in a stretch with no sender gaps
  int calm_left = 0;
  // cycles left before the receiver flips its stall
  int stall_span = 0;

  always #5 clk = ~clk;

  thruster_actuator_model #(.DELAY_TICKS(DELAY_TICKS)) dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .force_command    (force_command),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .applied_force    (applied_force),
    .target_force     (target_force),
    .watchdog_stopped (watchdog_stopped)
  );

  // predicts every result and compares it on the output side
  thruster_force_checker #(.DELAY_TICKS(DELAY_TICKS)) force_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .force_command    (force_command),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .applied_force    (applied_force),
    .target_force     (target_force),
    .watchdog_stopped (watchdog_stopped),
    .failures         (failures),
    .outstanding      (outstanding)
  );

  // receiver back-pressure: alternating free and stalled spans,
  // mostly short stalls, now and then a long one, and long free runs too
  always @(posedge clk) begin : receiver
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (stall_span != 0) begin
      stall_span <= stall_span - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_span <= (pick < 15) ? $urandom_range(20, 80) : $urandom_range(0, 4);
    end else begin
      out_stall  <= 1'b1;
      stall_span <= (pick < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
    end
  end

  // one input transfer, preceded by a random gap; payload holds while stalled
  task automatic send_item(thrust_action_t act, logic [FORCE_W-1:0] cmd);
    int          gap;
    int unsigned sel;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      sel = $urandom_range(0, 999);
      if (sel < 10)
        calm_left = $urandom_range(20, 60);
      else if (sel < 300)
        gap = $urandom_range(1, 3);
      else if (sel < 380)
        gap = $urandom_range(4, 12);
      else if (sel < 400)
        gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    force_command <= cmd;
    do @(posedge clk); while (in_stall);
  endtask

  // sender goes quiet until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // a little margin after the last result
    repeat (2) @(posedge clk);
  endtask

  // cfg_write stays high across back-to-back writes; caller lowers it
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // command values: full range, small forces, the deadband edge and extremes
  function automatic logic [FORCE_W-1:0] pick_command();
    int unsigned       sel;
    logic [FORCE_W-1:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      v = $urandom;
    end else if (sel < 80) begin
      if (sel < 68)
        v = $urandom_range(0, 32'h0008_0000);
      else
        v = cur_deadband + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1) == 1)
        v = -v;
    end else begin
      case ($urandom_range(0, 5))
        0:       v = 32'h7fff_ffff;
        1:       v = 32'h8000_0000;
        2:       v = 32'h8000_0001;
        3:       v = 32'hffff_ffff;
        4:       v = 32'h0000_0001;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  // lag factors: mostly mid-range, with instant, near-frozen and above-one values
  function automatic logic [ALPHA_W-1:0] pick_alpha();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10)
      return ALPHA_ONE;
    if (sel < 15)
      return ALPHA_W'($urandom_range(ALPHA_ONE + 1, 17'h1ffff));
    if (sel < 25)
      return ALPHA_W'($urandom_range(0, 16));
    return ALPHA_W'($urandom_range(256, 65535));
  endfunction

  initial begin : stimulus
    logic [CFG_W-1:0]   db, fl, rl, ss;
    logic [GAIN_W-1:0]  fg, rg;
    logic [ALPHA_W-1:0] ra, fa;
    int                 budget, sent, n;
    int unsigned        sel;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings: unity gain, full limits, instant lag
    // first tick finds the channel stopped since reset and flushes
    send_item(ACT_TICK, 32'hffff_ffff);
    // full positive command, then overwritten before the next tick by full negative
    send_item(ACT_COMMAND, 32'h7fff_ffff);
    send_item(ACT_COMMAND, 32'h8000_0000);
    // let it mature; negative magnitude clamps to the reverse limit
    repeat (DELAY_TICKS + 1) send_item(ACT_TICK, $urandom);
    // sign reversal: target and force on opposite sides, fall factor
    send_item(ACT_COMMAND, 32'h7fff_ffff);
    repeat (DELAY_TICKS + 1) send_item(ACT_TICK, $urandom);
    // zero, then minus one lsb overwriting it
    send_item(ACT_COMMAND, '0);
    send_item(ACT_COMMAND, 32'hffff_ffff);
    repeat (DELAY_TICKS + 1) send_item(ACT_TICK, 32'h0);
    send_item(ACT_COMMAND, 32'h0000_0001);
    send_item(ACT_TICK, 32'hffff_ffff);

    // random part in phases, each with its own register settings
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          // nominal values, written explicitly
          db = DEADBAND_RST; fg = GAIN_RST; rg = GAIN_RST; fl = LIMIT_RST; rl = LIMIT_RST;
          ra = ALPHA_RST; fa = ALPHA_RST; ss = SLEW_RST;
        end
        1: begin
          // every register at its top value, alphas above one
          db = '1; fg = '1; rg = '1; fl = '1; rl = '1; ra = '1; fa = '1; ss = '1;
        end
        2: begin
          // every register at zero: nothing gets through, lag frozen
          db = '0; fg = '0; rg = '0; fl = '0; rl = '0; ra = '0; fa = '0; ss = '0;
        end
        3: begin
          // huge gain into tight asymmetric limits, one-lsb slew
          db = 31'd1; fg = '1; rg = '1; fl = 31'h0010_0000; rl = 31'h0000_8000;
          ra = 17'd1; fa = 17'd65535; ss = 31'd1;
        end
        default: begin
          db = ($urandom_range(0, 99) < 30) ? '0 : CFG_W'($urandom_range(1, 32'h0002_0000));
          fg = ($urandom_range(0, 99) < 20) ? GAIN_W'($urandom)
                                            : GAIN_W'($urandom_range(24'h004000, 24'h040000));
          rg = ($urandom_range(0, 99) < 20) ? GAIN_W'($urandom)
                                            : GAIN_W'($urandom_range(24'h004000, 24'h040000));
          fl = ($urandom_range(0, 1) == 1) ? CFG_W'($urandom)
                                           : CFG_W'($urandom_range(32'h0001_0000, 32'h0100_0000));
          rl = ($urandom_range(0, 1) == 1) ? CFG_W'($urandom)
                                           : CFG_W'($urandom_range(32'h0001_0000, 32'h0100_0000));
          ra = pick_alpha();
          fa = pick_alpha();
          ss = ($urandom_range(0, 99) < 40) ? '0 : CFG_W'($urandom_range(1, 32'h0004_0000));
        end
      endcase
      write_reg(REG_DEADBAND, db);
      write_reg(REG_FORWARD_GAIN, fg);
      write_reg(REG_REVERSE_GAIN, rg);
      write_reg(REG_FORWARD_LIMIT, fl);
      write_reg(REG_REVERSE_LIMIT, rl);
      write_reg(REG_RISE_ALPHA, ra);
      write_reg(REG_FALL_ALPHA, fa);
      write_reg(REG_SLEW_STEP, ss);
      cfg_write    <= 1'b0;
      cur_deadband = db;

      // the extreme phases are short, the rest share the budget
      budget = (p >= 1 && p <= 3) ? 50 : (ITEM_BUDGET - 150) / (PHASES - 3);
      sent = 0;
      while (sent < budget) begin
        sel = $urandom_range(0, 99);
        if (sel < 66) begin
          // command followed by a few ticks, well inside the watchdog window
          send_item(ACT_COMMAND, pick_command());
          n = $urandom_range(1, 2 * DELAY_TICKS);
          repeat (n) send_item(ACT_TICK, $urandom);
          sent += n + 1;
        end else if (sel < 78) begin
          // several commands in one tick, only the last one counts
          n = $urandom_range(2, 4);
          repeat (n) send_item(ACT_COMMAND, pick_command());
          send_item(ACT_TICK, $urandom);
          sent += n + 1;
        end else if (sel < 79) begin
          // long silence around the timeout so the watchdog trips (or just misses)
          n = $urandom_range(TIMEOUT_TICKS - 2, TIMEOUT_TICKS + 12);
          repeat (n) send_item(ACT_TICK, $urandom);
          sent += n;
        end else if (sel < 81) begin
          // sender holds off until the block has nothing left in flight
          wait_drained();
        end else begin
          send_item(thrust_action_t'($urandom_range(0, 1)), $urandom);
          sent++;
        end
      end
    end

    wait_drained();
    if (failures == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // hard stop in case a handshake never completes
  initial begin : run_limit
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
